// ----- rtl/core/polygon_edge_intersection_test_assert.svh -----
// ----------------------------------------------------------------------------
// polygon_edge_intersection_test_assert.svh
// assertion macros shared by the polygon edge crossing checker
// ----------------------------------------------------------------------------
`ifndef POLYGON_EDGE_INTERSECTION_TEST_ASSERT_SVH
`define POLYGON_EDGE_INTERSECTION_TEST_ASSERT_SVH

// same-cycle implication
`define PET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pet_pkg.sv -----
// ----------------------------------------------------------------------------
// pet_pkg
// types, microcode table and arithmetic helpers of the polygon edge crossing test
// ----------------------------------------------------------------------------
package pet_pkg;

    localparam int COORD_BITS = 16;
    localparam int VERT_BITS  = COORD_BITS + 1;
    localparam int DIFF_BITS  = VERT_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int ACC_BITS   = PROD_BITS + 1;
    localparam int PC_BITS    = 4;

    typedef enum logic [1:0] {
        OP_LOAD_OTHER = 2'd0,
        OP_LOAD_OWN   = 2'd1,
        OP_TEST       = 2'd2
    } opcode_t;

    typedef struct packed {
        opcode_t                       opcode;
        logic signed [COORD_BITS-1:0]  point_x;
        logic signed [COORD_BITS-1:0]  point_y;
        logic signed [COORD_BITS-1:0]  origin_x;
        logic signed [COORD_BITS-1:0]  origin_y;
    } cmd_t;

    typedef struct packed {
        logic collide;
        logic overflow;
    } result_t;

    typedef struct packed {
        logic signed [VERT_BITS-1:0] x;
        logic signed [VERT_BITS-1:0] y;
    } vertex_t;

    typedef logic signed [DIFF_BITS-1:0] diff_t;
    typedef logic signed [ACC_BITS-1:0]  acc_t;
    typedef logic [PC_BITS-1:0]          pc_t;

    typedef enum logic [2:0] {
        MUL_DX_EY = 3'd0,
        MUL_DY_EX = 3'd1,
        MUL_WY_EX = 3'd2,
        MUL_WX_EY = 3'd3,
        MUL_DX_WY = 3'd4,
        MUL_DY_WX = 3'd5
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD = 3'd0,
        ACC_LOAD = 3'd1,
        ACC_DEN  = 3'd2,
        ACC_TN   = 3'd3,
        ACC_UN   = 3'd4
    } acc_op_t;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_EMPTY    = 3'd1,
        COND_DEN_ZERO = 3'd2,
        COND_T_OUT    = 3'd3,
        COND_U_IN     = 3'd4,
        COND_MORE     = 3'd5
    } cond_t;

    typedef enum logic [1:0] {
        EMIT_NONE = 2'd0,
        EMIT_MISS = 2'd1,
        EMIT_HIT  = 2'd2
    } emit_t;

    typedef struct packed {
        logic     clr_idx;
        logic     ld_diff;
        logic     adv_idx;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        cond_t    cond;
        pc_t      target;
        emit_t    emit;
    } uword_t;

    typedef struct packed {
        logic empty;
        logic den_zero;
        logic t_out;
        logic u_in;
        logic last;
    } status_t;

    localparam uword_t UWORD_NOP = '0;

    localparam pc_t STEP_ENTRY    = 4'd0;
    localparam pc_t STEP_READ     = 4'd1;
    localparam pc_t STEP_DIFF     = 4'd2;
    localparam pc_t STEP_MUL_DEN0 = 4'd3;
    localparam pc_t STEP_MUL_DEN1 = 4'd4;
    localparam pc_t STEP_MUL_TN0  = 4'd5;
    localparam pc_t STEP_MUL_TN1  = 4'd6;
    localparam pc_t STEP_MUL_UN0  = 4'd7;
    localparam pc_t STEP_MUL_UN1  = 4'd8;
    localparam pc_t STEP_UN       = 4'd9;
    localparam pc_t STEP_CHK_U    = 4'd10;
    localparam pc_t STEP_NEXT     = 4'd11;
    localparam pc_t STEP_FIN_MISS = 4'd12;
    localparam pc_t STEP_FIN_HIT  = 4'd13;

    // microcode rom
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        begin
            w = UWORD_NOP;
            unique case (pc)
                STEP_ENTRY:
                begin
                    w.clr_idx = 1'b1;
                    w.cond    = COND_EMPTY;
                    w.target  = STEP_FIN_MISS;
                end
                STEP_READ:
                begin
                    w.cond = COND_NEVER;
                end
                STEP_DIFF:
                begin
                    w.ld_diff = 1'b1;
                end
                STEP_MUL_DEN0:
                begin
                    w.mul_sel = MUL_DX_EY;
                end
                STEP_MUL_DEN1:
                begin
                    w.mul_sel = MUL_DY_EX;
                    w.acc_op  = ACC_LOAD;
                end
                STEP_MUL_TN0:
                begin
                    w.mul_sel = MUL_WY_EX;
                    w.acc_op  = ACC_DEN;
                end
                STEP_MUL_TN1:
                begin
                    w.mul_sel = MUL_WX_EY;
                    w.acc_op  = ACC_LOAD;
                    w.cond    = COND_DEN_ZERO;
                    w.target  = STEP_NEXT;
                end
                STEP_MUL_UN0:
                begin
                    w.mul_sel = MUL_DX_WY;
                    w.acc_op  = ACC_TN;
                end
                STEP_MUL_UN1:
                begin
                    w.mul_sel = MUL_DY_WX;
                    w.acc_op  = ACC_LOAD;
                    w.cond    = COND_T_OUT;
                    w.target  = STEP_NEXT;
                end
                STEP_UN:
                begin
                    w.acc_op = ACC_UN;
                end
                STEP_CHK_U:
                begin
                    w.cond   = COND_U_IN;
                    w.target = STEP_FIN_HIT;
                end
                STEP_NEXT:
                begin
                    w.adv_idx = 1'b1;
                    w.cond    = COND_MORE;
                    w.target  = STEP_READ;
                end
                STEP_FIN_MISS:
                begin
                    w.emit = EMIT_MISS;
                end
                STEP_FIN_HIT:
                begin
                    w.emit = EMIT_HIT;
                end
                default:
                begin
                    w.emit = EMIT_MISS;
                end
            endcase
            return w;
        end
    endfunction

    function automatic diff_t vdiff(input logic [VERT_BITS-1:0] a,
                                    input logic [VERT_BITS-1:0] b);
        begin
            return diff_t'({a[VERT_BITS-1], a} - {b[VERT_BITS-1], b});
        end
    endfunction

    // num / den lies in [0,1), den nonzero
    function automatic logic in_unit(input acc_t num, input acc_t den);
        logic den_pos;
        logic num_nonneg;
        logic num_nonpos;
        begin
            den_pos    = !den[ACC_BITS-1] && (den != '0);
            num_nonneg = !num[ACC_BITS-1];
            num_nonpos = num[ACC_BITS-1] || (num == '0);
            if (den_pos)
            begin
                return num_nonneg && (num < den);
            end
            return num_nonpos && (num > den);
        end
    endfunction

endpackage

// ----- rtl/core/pet_vertex_mem.sv -----
// ----------------------------------------------------------------------------
// pet_vertex_mem
// vertex store of one polygon, one write port and two registered read ports
// ----------------------------------------------------------------------------
module pet_vertex_mem #(
    parameter int DEPTH = 8
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  pet_pkg::vertex_t             wr_data,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr_b,
    output pet_pkg::vertex_t             rd_data_a,
    output pet_pkg::vertex_t             rd_data_b
);
    import pet_pkg::*;

    vertex_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- rtl/core/pet_sequencer.sv -----
// ----------------------------------------------------------------------------
// pet_sequencer
// step counter over the microcode rom with conditional jumps
// ----------------------------------------------------------------------------
module pet_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              launch,
    input  pet_pkg::status_t  status,
    output pet_pkg::uword_t   ctl,
    output logic              busy
);
    import pet_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t word;
    logic   take;

    always_comb
    begin
        word = ucode(pc_reg);
        unique case (word.cond)
            COND_NEVER:    take = 1'b0;
            COND_EMPTY:    take = status.empty;
            COND_DEN_ZERO: take = status.den_zero;
            COND_T_OUT:    take = status.t_out;
            COND_U_IN:     take = status.u_in;
            COND_MORE:     take = !status.last;
            default:       take = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (launch)
                begin
                    state_next = ST_RUN;
                    pc_next    = STEP_ENTRY;
                end
            end
            ST_RUN:
            begin
                if (word.emit != EMIT_NONE)
                begin
                    state_next = ST_IDLE;
                end
                else if (take)
                begin
                    pc_next = word.target;
                end
                else
                begin
                    pc_next = pc_reg + PC_BITS'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= STEP_ENTRY;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    assign busy = (state_reg == ST_RUN);
    assign ctl  = (state_reg == ST_RUN) ? word : UWORD_NOP;

endmodule

// ----- rtl/core/pet_datapath.sv -----
// ----------------------------------------------------------------------------
// pet_datapath
// vertex counts, edge indices, difference vectors, shared multiplier and
// accumulator, range checks and result register
// ----------------------------------------------------------------------------
module pet_datapath #(
    parameter int MAX_POINTS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  pet_pkg::cmd_t                     item,
    input  pet_pkg::uword_t                   ctl,
    input  pet_pkg::vertex_t                  oth_a,
    input  pet_pkg::vertex_t                  oth_b,
    input  pet_pkg::vertex_t                  own_a,
    input  pet_pkg::vertex_t                  own_b,
    output logic                              oth_wr_en,
    output logic                              own_wr_en,
    output logic [$clog2(MAX_POINTS)-1:0]     oth_wr_addr,
    output logic [$clog2(MAX_POINTS)-1:0]     own_wr_addr,
    output pet_pkg::vertex_t                  wr_vertex,
    output logic [$clog2(MAX_POINTS)-1:0]     oth_rd_a,
    output logic [$clog2(MAX_POINTS)-1:0]     oth_rd_b,
    output logic [$clog2(MAX_POINTS)-1:0]     own_rd_a,
    output logic [$clog2(MAX_POINTS)-1:0]     own_rd_b,
    output pet_pkg::status_t                  status,
    output logic                              done,
    output pet_pkg::result_t                  result
);
    import pet_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_POINTS);

    logic [CW-1:0] oth_count_reg;
    logic [CW-1:0] own_count_reg;
    logic          dropped_reg;
    logic [AW-1:0] i_reg;
    logic [AW-1:0] j_reg;
    logic          i_last;
    logic          j_last;
    logic          load_oth;
    logic          load_own;
    logic          emit;

    diff_t dx_reg;
    diff_t dy_reg;
    diff_t ex_reg;
    diff_t ey_reg;
    diff_t wx_reg;
    diff_t wy_reg;
    diff_t mop_a;
    diff_t mop_b;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [PROD_BITS-1:0] prod_reg;
    acc_t  prod_ext;
    acc_t  acc_reg;
    acc_t  den_reg;
    acc_t  tn_reg;
    acc_t  un_reg;
    logic    done_reg;
    result_t result_reg;

    // vertex is point plus origin
    assign wr_vertex.x = {item.point_x[COORD_BITS-1], item.point_x}
                       + {item.origin_x[COORD_BITS-1], item.origin_x};
    assign wr_vertex.y = {item.point_y[COORD_BITS-1], item.point_y}
                       + {item.origin_y[COORD_BITS-1], item.origin_y};

    assign load_oth    = accept && (item.opcode == OP_LOAD_OTHER);
    assign load_own    = accept && (item.opcode == OP_LOAD_OWN);
    assign oth_wr_en   = load_oth && (oth_count_reg < MAX_COUNT);
    assign own_wr_en   = load_own && (own_count_reg < MAX_COUNT);
    assign oth_wr_addr = oth_count_reg[AW-1:0];
    assign own_wr_addr = own_count_reg[AW-1:0];
    assign emit        = (ctl.emit != EMIT_NONE);

    // closing edge wraps to vertex zero
    assign i_last   = ((CW'(i_reg) + CW'(1)) == oth_count_reg);
    assign j_last   = ((CW'(j_reg) + CW'(1)) == own_count_reg);
    assign oth_rd_a = i_reg;
    assign oth_rd_b = i_last ? '0 : i_reg + AW'(1);
    assign own_rd_a = j_reg;
    assign own_rd_b = j_last ? '0 : j_reg + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oth_count_reg <= '0;
            own_count_reg <= '0;
            dropped_reg   <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= emit;
            if (emit)
            begin
                oth_count_reg <= '0;
                own_count_reg <= '0;
                dropped_reg   <= 1'b0;
            end
            else
            begin
                if (oth_wr_en)
                begin
                    oth_count_reg <= oth_count_reg + CW'(1);
                end
                if (own_wr_en)
                begin
                    own_count_reg <= own_count_reg + CW'(1);
                end
                if ((load_oth && !oth_wr_en) || (load_own && !own_wr_en))
                begin
                    dropped_reg <= 1'b1;
                end
            end
            if (ctl.clr_idx)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            else if (ctl.adv_idx)
            begin
                if (j_last)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + AW'(1);
                end
                else
                begin
                    j_reg <= j_reg + AW'(1);
                end
            end
        end
    end

    always_comb
    begin
        unique case (ctl.mul_sel)
            MUL_DX_EY:
            begin
                mop_a = dx_reg;
                mop_b = ey_reg;
            end
            MUL_DY_EX:
            begin
                mop_a = dy_reg;
                mop_b = ex_reg;
            end
            MUL_WY_EX:
            begin
                mop_a = wy_reg;
                mop_b = ex_reg;
            end
            MUL_WX_EY:
            begin
                mop_a = wx_reg;
                mop_b = ey_reg;
            end
            MUL_DX_WY:
            begin
                mop_a = dx_reg;
                mop_b = wy_reg;
            end
            MUL_DY_WX:
            begin
                mop_a = dy_reg;
                mop_b = wx_reg;
            end
            default:
            begin
                mop_a = dx_reg;
                mop_b = ey_reg;
            end
        endcase
    end

    assign prod     = mop_a * mop_b;
    assign prod_ext = {prod_reg[PROD_BITS-1], prod_reg};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        if (ctl.ld_diff)
        begin
            dx_reg <= vdiff(oth_b.x, oth_a.x);
            dy_reg <= vdiff(oth_b.y, oth_a.y);
            ex_reg <= vdiff(own_b.x, own_a.x);
            ey_reg <= vdiff(own_b.y, own_a.y);
            wx_reg <= vdiff(oth_a.x, own_a.x);
            wy_reg <= vdiff(oth_a.y, own_a.y);
        end
        unique case (ctl.acc_op)
            ACC_HOLD: ;
            ACC_LOAD: acc_reg <= prod_ext;
            ACC_DEN:  den_reg <= acc_reg - prod_ext;
            ACC_TN:   tn_reg  <= acc_reg - prod_ext;
            ACC_UN:   un_reg  <= acc_reg - prod_ext;
            default: ;
        endcase
        if (emit)
        begin
            result_reg.collide  <= (ctl.emit == EMIT_HIT);
            result_reg.overflow <= dropped_reg;
        end
    end

    assign status.empty    = (oth_count_reg == '0) || (own_count_reg == '0);
    assign status.den_zero = (den_reg == '0);
    assign status.t_out    = !in_unit(tn_reg, den_reg);
    assign status.u_in     = in_unit(un_reg, den_reg);
    assign status.last     = i_last && j_last;

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/core/polygon_edge_intersection_test.sv -----
// ----------------------------------------------------------------------------
// polygon_edge_intersection_test
// edge crossing test between two closed polygons held in small vertex stores
// ----------------------------------------------------------------------------
// usage
//   item beat taken at a clock edge with start high and busy low
//   load other / load own: vertex = point + origin stored at the beat,
//     busy stays low; a load into a full polygon is dropped and flagged
//   test: busy rises the cycle after the beat; one result beat follows with
//     done high for one cycle; as it rises both polygons and the drop flag clear
//   a pair rejected early (parallel edges, t outside [0,1)) takes fewer
//     microcode steps, and the walk stops at the first crossing pair
//   the walk is paced by the single shared multiplier: six products per
//     edge pair, issued one per microcode step
//   an empty polygon gives collide 0 from the entry step, with no edge walk
//   reset clears counts, drop flag and sequencer; vertex stores need no clear
//   results cannot be held off, done is a one-cycle strobe
// ----------------------------------------------------------------------------
module polygon_edge_intersection_test #(
    parameter int MAX_POINTS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pet_pkg::cmd_t     item,
    output logic              done,
    output pet_pkg::result_t  result
);
    import pet_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    logic          accept;
    logic          launch;
    uword_t        ctl;
    status_t       status;
    vertex_t       wr_vertex;
    vertex_t       oth_a;
    vertex_t       oth_b;
    vertex_t       own_a;
    vertex_t       own_b;
    logic          oth_wr_en;
    logic          own_wr_en;
    logic [AW-1:0] oth_wr_addr;
    logic [AW-1:0] own_wr_addr;
    logic [AW-1:0] oth_rd_a;
    logic [AW-1:0] oth_rd_b;
    logic [AW-1:0] own_rd_a;
    logic [AW-1:0] own_rd_b;

    assign accept = start && !busy;
    assign launch = accept && (item.opcode == OP_TEST);

    pet_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (launch),
        .status (status),
        .ctl    (ctl),
        .busy   (busy)
    );

    pet_vertex_mem #(
        .DEPTH (MAX_POINTS)
    ) u_oth_mem (
        .clk       (clk),
        .wr_en     (oth_wr_en),
        .wr_addr   (oth_wr_addr),
        .wr_data   (wr_vertex),
        .rd_addr_a (oth_rd_a),
        .rd_addr_b (oth_rd_b),
        .rd_data_a (oth_a),
        .rd_data_b (oth_b)
    );

    pet_vertex_mem #(
        .DEPTH (MAX_POINTS)
    ) u_own_mem (
        .clk       (clk),
        .wr_en     (own_wr_en),
        .wr_addr   (own_wr_addr),
        .wr_data   (wr_vertex),
        .rd_addr_a (own_rd_a),
        .rd_addr_b (own_rd_b),
        .rd_data_a (own_a),
        .rd_data_b (own_b)
    );

    pet_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .ctl         (ctl),
        .oth_a       (oth_a),
        .oth_b       (oth_b),
        .own_a       (own_a),
        .own_b       (own_b),
        .oth_wr_en   (oth_wr_en),
        .own_wr_en   (own_wr_en),
        .oth_wr_addr (oth_wr_addr),
        .own_wr_addr (own_wr_addr),
        .wr_vertex   (wr_vertex),
        .oth_rd_a    (oth_rd_a),
        .oth_rd_b    (oth_rd_b),
        .own_rd_a    (own_rd_a),
        .own_rd_b    (own_rd_b),
        .status      (status),
        .done        (done),
        .result      (result)
    );

endmodule

// ----- rtl/core/pet_checker.sv -----
// ----------------------------------------------------------------------------
// pet_checker
// port-level checks of the command and result beats, bound to the top level
// ----------------------------------------------------------------------------
`include "polygon_edge_intersection_test_assert.svh"

module pet_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input pet_pkg::cmd_t  item
);
    import pet_pkg::*;

    logic take_test;
    logic take_load;

    assign take_test = start && !busy && (item.opcode == OP_TEST);
    assign take_load = start && !busy && (item.opcode != OP_TEST);

    `PET_ASSERT_NEXT(a_test_goes_busy, clk, rst_n, take_test, busy && !done, "test beat did not start the walk")
    `PET_ASSERT_NOW(a_done_when_idle, clk, rst_n, done, !busy, "result beat while still busy")
    `PET_ASSERT_NOW(a_busy_ends_with_result, clk, rst_n, $fell(busy), done, "walk ended without a result beat")
    `PET_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "result beat repeated")
    `PET_ASSERT_NEXT(a_load_no_result, clk, rst_n, take_load, !busy && !done, "load beat caused work or a result")

endmodule

bind polygon_edge_intersection_test pet_checker u_pet_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .item  (item)
);
